// File: rtl/triangle_vertical_split_ratio_core_macros.svh
// Assertion helpers for the split ratio core.
`ifndef TRIANGLE_VERTICAL_SPLIT_RATIO_CORE_MACROS_SVH
`define TRIANGLE_VERTICAL_SPLIT_RATIO_CORE_MACROS_SVH
`ifndef SYNTHESIS
// cond must hold at every edge out of reset
`define TVSR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
// trig at one edge implies cons at the same edge
`define TVSR_ASSERT_IMPLY(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error("assertion failed");
`else
`define TVSR_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define TVSR_ASSERT_IMPLY(label, clk, rst_n, trig, cons)
`endif
`endif

// File: rtl/tvsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tvsr_pkg;

	localparam int RATIO_FRAC_BITS = 16;
	localparam int QUO_BITS        = RATIO_FRAC_BITS + 2;
	localparam int PROD_BITS       = 64;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] line_x;
	} tvsr_in_t;

	typedef struct packed {
		logic [16:0] ratio;
		logic        hit;
		logic        degenerate;
	} tvsr_out_t;

	typedef struct packed {
		logic hit;
		logic degenerate;
	} tvsr_flags_t;

	// divider stage payload
	typedef struct packed {
		logic [PROD_BITS:0]   rem;
		logic [PROD_BITS-1:0] den;
		logic [QUO_BITS-1:0]  quo;
		tvsr_flags_t          flags;
	} tvsr_div_t;

endpackage
`default_nettype wire

// File: rtl/tvsr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tvsr_front import tvsr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_valid,
	input  wire tvsr_in_t  in_item,
	output logic           valid_s4,
	output tvsr_div_t      div_s4
);

	function automatic logic signed [31:0] pick3(input logic [2:0] oh,
		input logic signed [31:0] a, input logic signed [31:0] b,
		input logic signed [31:0] c);
		return ({32{oh[0]}} & a) | ({32{oh[1]}} & b) | ({32{oh[2]}} & c);
	endfunction

	// stage 1: edge deltas, sort order
	logic               valid_s1, valid_s2, valid_s3;
	logic signed [32:0] d_ba_s1, d_ca_s1, d_cya_s1, d_bya_s1;
	logic signed [31:0] ax_s1, bx_s1, cx_s1, lx_s1;
	logic [2:0]         min_oh_s1, max_oh_s1;
	logic               gab, gac, gbc;
	logic [2:0]         min_oh, max_oh;

	always_comb begin
		gab = in_item.ax > in_item.bx;
		gac = in_item.ax > in_item.cx;
		gbc = in_item.bx > in_item.cx;
		// min favors a then b; max favors c then b
		if (!gab && !gac) begin
			min_oh = 3'b001;
		end else if (!gbc) begin
			min_oh = 3'b010;
		end else begin
			min_oh = 3'b100;
		end
		if (!gac && !gbc) begin
			max_oh = 3'b100;
		end else if (!gab) begin
			max_oh = 3'b010;
		end else begin
			max_oh = 3'b001;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_ba_s1   <= {in_item.bx[31], in_item.bx} - {in_item.ax[31], in_item.ax};
			d_ca_s1   <= {in_item.cx[31], in_item.cx} - {in_item.ax[31], in_item.ax};
			d_cya_s1  <= {in_item.cy[31], in_item.cy} - {in_item.ay[31], in_item.ay};
			d_bya_s1  <= {in_item.by[31], in_item.by} - {in_item.ay[31], in_item.ay};
			ax_s1     <= in_item.ax;
			bx_s1     <= in_item.bx;
			cx_s1     <= in_item.cx;
			lx_s1     <= in_item.line_x;
			min_oh_s1 <= min_oh;
			max_oh_s1 <= max_oh;
		end
	end

	// stage 2: cross products, sorted x, span test, factor select
	logic signed [65:0] p1_s2, p2_s2;
	logic [31:0]        dn_s2, f1_s2, f2_s2;
	logic               hit_s2;
	logic signed [31:0] x0, x1, x2;
	logic signed [32:0] l_x0, x2_l, x1_x0, x2_x1, x2_x0;
	logic               left;

	always_comb begin
		x0    = pick3(min_oh_s1, ax_s1, bx_s1, cx_s1);
		x2    = pick3(max_oh_s1, ax_s1, bx_s1, cx_s1);
		x1    = pick3(~(min_oh_s1 | max_oh_s1), ax_s1, bx_s1, cx_s1);
		l_x0  = {lx_s1[31], lx_s1} - {x0[31], x0};
		x2_l  = {x2[31], x2} - {lx_s1[31], lx_s1};
		x1_x0 = {x1[31], x1} - {x0[31], x0};
		x2_x1 = {x2[31], x2} - {x1[31], x1};
		x2_x0 = {x2[31], x2} - {x0[31], x0};
		left  = lx_s1 <= x1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2  <= d_ba_s1 * d_cya_s1;
			p2_s2  <= d_ca_s1 * d_bya_s1;
			hit_s2 <= (lx_s1 >= x0) && (lx_s1 <= x2);
			dn_s2  <= left ? l_x0[31:0] : x2_l[31:0];
			f1_s2  <= left ? x1_x0[31:0] : x2_x1[31:0];
			f2_s2  <= x2_x0[31:0];
		end
	end

	// stage 3: squared cut width and area denominator
	logic [PROD_BITS-1:0] num_s3, den_s3;
	tvsr_flags_t          flags_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3              <= dn_s2 * dn_s2;
			den_s3              <= f1_s2 * f2_s2;
			flags_s3.hit        <= hit_s2;
			flags_s3.degenerate <= p1_s2 == p2_s2;
		end
	end

	// stage 4: clamp, force zero ratio on miss, zero area or zero denominator
	logic [PROD_BITS-1:0] num_c;
	logic                 force0;

	always_comb begin
		num_c  = (num_s3 > den_s3) ? den_s3 : num_s3;
		force0 = !flags_s3.hit || flags_s3.degenerate || (den_s3 == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s4.rem   <= force0 ? '0 : {1'b0, num_c};
			div_s4.den   <= force0 ? PROD_BITS'(1) : den_s3;
			div_s4.quo   <= '0;
			div_s4.flags <= flags_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

endmodule
`default_nettype wire

// File: rtl/tvsr_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module tvsr_div_stage import tvsr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_valid,
	input  wire tvsr_div_t in_div,
	output logic           valid_s1,
	output tvsr_div_t      div_s1
);

	// one restoring step; the caller supplies the already shifted remainder
	logic             ge;
	logic [PROD_BITS:0] diff;

	always_comb begin
		diff = in_div.rem - {1'b0, in_div.den};
		ge   = in_div.rem >= {1'b0, in_div.den};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s1.rem   <= ge ? diff : in_div.rem;
			div_s1.den   <= in_div.den;
			div_s1.quo   <= {in_div.quo[QUO_BITS-2:0], ge};
			div_s1.flags <= in_div.flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

endmodule
`default_nettype wire

// File: rtl/triangle_vertical_split_ratio_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                   Payload
// item      item_valid / item_ready     item   (tvsr_in_t: 3 vertices, line_x)
// result    result_valid / result_ready result (tvsr_out_t: ratio, hit, degenerate)
//
// One transaction per cycle sustained while results are taken. The depth
// is set by the 18 restoring divider steps, one per stage, after four
// front stages and the output register. Reset clears only the valid bits.
// The whole pipe advances together and freezes while the output register
// holds a result that is not taken.
`include "triangle_vertical_split_ratio_core_macros.svh"
module triangle_vertical_split_ratio_core import tvsr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_ready,
	input  wire tvsr_in_t  item,
	output logic           result_valid,
	input  wire logic      result_ready,
	output tvsr_out_t      result
);

	// global advance: the output register is empty or being drained
	logic advance;
	assign advance    = !result_valid || result_ready;
	assign item_ready = advance;

	// front: deltas, sort, span test, products, clamp
	logic      front_valid;
	tvsr_div_t front_div;

	tvsr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.in_valid (item_valid),
		.in_item  (item),
		.valid_s4 (front_valid),
		.div_s4   (front_div)
	);

	// divider: one quotient bit per stage, MSB first (integer bit, then 17)
	logic      div_v [QUO_BITS+1];
	tvsr_div_t div_p [QUO_BITS+1];

	assign div_v[0] = front_valid;
	assign div_p[0] = front_div;

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
		tvsr_div_t step_in;
		always_comb begin
			step_in = div_p[k];
			// first step compares the raw numerator; later ones shift left
			if (k != 0) begin
				step_in.rem = {div_p[k].rem[PROD_BITS-1:0], 1'b0};
			end
		end
		tvsr_div_stage u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (advance),
			.in_valid (div_v[k]),
			.in_div   (step_in),
			.valid_s1 (div_v[k+1]),
			.div_s1   (div_p[k+1])
		);
	end

	// output register: round half up by dropping the guard bit
	logic [QUO_BITS:0] rounded;
	assign rounded = {1'b0, div_p[QUO_BITS].quo} + (QUO_BITS+1)'(1);

	always_ff @(posedge clk) begin
		if (advance) begin
			result.ratio      <= rounded[17:1];
			result.hit        <= div_p[QUO_BITS].flags.hit;
			result.degenerate <= div_p[QUO_BITS].flags.degenerate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= div_v[QUO_BITS];
		end
	end

	// zero-area triangles never report a nonzero ratio
	`TVSR_ASSERT_IMPLY(a_degen_zero, clk, arst_n, result_valid && result.degenerate, result.ratio == 17'd0)
	// a line outside the span never reports a nonzero ratio
	`TVSR_ASSERT_IMPLY(a_miss_zero, clk, arst_n, result_valid && !result.hit, result.ratio == 17'd0)
	// the ratio never exceeds one
	`TVSR_ASSERT_IMPLY(a_ratio_max, clk, arst_n, result_valid, result.ratio <= 17'd65536)

endmodule
`default_nettype wire

// File: verif/triangle_vertical_split_ratio_checker.sv
`timescale 1ns / 1ps
module triangle_vertical_split_ratio_checker import tvsr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      item_ready,
	input  tvsr_in_t  item,
	input  logic      result_valid,
	input  logic      result_ready,
	input  tvsr_out_t result,
	output int        fail_count,
	output int        pending
);

	tvsr_out_t expected_splits[$];

	// round(num * 2^16 / den), ties up
	function automatic logic [16:0] round_fraction(logic [63:0] num, logic [63:0] den);
		logic [64:0] rem;
		logic [17:0] quo;
		if (den == 0) begin
			return '0;
		end
		rem = {1'b0, num};
		quo = '0;
		if (rem >= {1'b0, den}) begin
			quo = 1;
			rem = rem - {1'b0, den};
		end
		for (int i = 0; i < 17; i++) begin
			rem = rem << 1;
			quo = quo << 1;
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[0] = 1'b1;
			end
		end
		return 17'((quo + 18'd1) >> 1);
	endfunction

	function automatic tvsr_out_t predict_split(tvsr_in_t t);
		tvsr_out_t   r;
		logic signed [63:0] ax, ay, bx, by, cx, cy, lx, x0, x1, x2, tmp;
		logic signed [127:0] p1, p2;
		logic [63:0] d, num, den;
		ax = t.ax; ay = t.ay; bx = t.bx; by = t.by; cx = t.cx; cy = t.cy;
		lx = t.line_x;
		p1 = 128'(bx - ax) * 128'(cy - ay);
		p2 = 128'(cx - ax) * 128'(by - ay);
		r.degenerate = (p1 == p2);
		x0 = ax; x1 = bx; x2 = cx;
		if (x0 > x1) begin tmp = x0; x0 = x1; x1 = tmp; end
		if (x0 > x2) begin tmp = x0; x0 = x2; x2 = tmp; end
		if (x1 > x2) begin tmp = x1; x1 = x2; x2 = tmp; end
		r.hit = (lx >= x0) && (lx <= x2);
		r.ratio = '0;
		if (r.hit && !r.degenerate) begin
			if (lx <= x1) begin
				d = lx - x0;
				den = (x1 - x0) * (x2 - x0);
			end else begin
				d = x2 - lx;
				den = (x2 - x1) * (x2 - x0);
			end
			num = d * d;
			if (num > den) begin
				num = den;
			end
			r.ratio = round_fraction(num, den);
		end
		return r;
	endfunction

	assign pending = expected_splits.size();

	always @(posedge clk or negedge arst_n) begin
		tvsr_out_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (item_valid && item_ready) begin
				expected_splits.push_back(predict_split(item));
			end
			if (result_valid && result_ready) begin
				if (expected_splits.size() == 0) begin
					if (fail_count < 10) begin
						$display("unexpected result %p", result);
					end
					fail_count <= fail_count + 1;
				end else begin
					want = expected_splits.pop_front();
					if (result !== want) begin
						if (fail_count < 10) begin
							$display("mismatch: expected ratio=%0d hit=%0b deg=%0b, got ratio=%0d hit=%0b deg=%0b",
								want.ratio, want.hit, want.degenerate,
								result.ratio, result.hit, result.degenerate);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// File: verif/triangle_vertical_split_ratio_core_test.sv
`timescale 1ns / 1ps
module triangle_vertical_split_ratio_core_test import tvsr_pkg::*;;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RANDOM_ITEMS   = 1400;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	tvsr_in_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	tvsr_out_t result;
	int        fail_count;
	int        pending;

	// idle rates in percent, changed per phase
	int        send_idle = 25;
	int        recv_idle = 81;
	int        hold_off = 0;    // cycles left in a long receiver stall
	int        idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	triangle_vertical_split_ratio_core u_top (
		.clk, .arst_n, .item_valid, .item_ready, .item,
		.result_valid, .result_ready, .result
	);

	triangle_vertical_split_ratio_checker u_checker (
		.clk, .arst_n, .item_valid, .item_ready, .item,
		.result_valid, .result_ready, .result, .fail_count, .pending
	);

	// receiver: random stalls, plus an optional long hold-off
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// watchdog: cycles without any transaction on either channel
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || hold_off > 0) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one transaction; random gaps drop valid, valid held until accepted
	task automatic send_triangle(tvsr_in_t t);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= t;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(200)) - 100) <<< 16;
			2: return 32'($signed($urandom_range(2000)) - 1000);
			default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
				: 32'h8000_0000 + $urandom_range(3);
		endcase
	endfunction

	// triangle with random coordinates; line biased into the x-span
	function automatic tvsr_in_t random_triangle();
		tvsr_in_t t;
		int mode;
		logic signed [31:0] lo, hi;
		mode = ($urandom_range(9) == 0) ? 3 : $urandom_range(2);
		t.ax = rand_coord(mode); t.ay = rand_coord(mode);
		t.bx = rand_coord(mode); t.by = rand_coord(mode);
		t.cx = rand_coord(mode); t.cy = rand_coord(mode);
		case ($urandom_range(9))
			0: t.cx = t.bx;                      // shared x
			1: begin t.cx = t.ax; t.cy = t.ay; end // coincident, degenerate
			2: begin t.bx = t.ax; t.cx = t.ax; end // vertical line, degenerate
			default: ;
		endcase
		lo = t.ax; hi = t.ax;
		if (t.bx < lo) lo = t.bx;
		if (t.cx < lo) lo = t.cx;
		if (t.bx > hi) hi = t.bx;
		if (t.cx > hi) hi = t.cx;
		case ($urandom_range(9))
			0: t.line_x = rand_coord(0);
			1: t.line_x = lo;
			2: t.line_x = hi;
			3: t.line_x = t.bx;
			default: t.line_x = lo + 32'((64'(hi) - 64'(lo)) * $urandom_range(1000) / 1000);
		endcase
		return t;
	endfunction

	function automatic tvsr_in_t tri_of(int ax, int ay, int bx, int by, int cx, int cy, int lx);
		tvsr_in_t t;
		t.ax = ax; t.ay = ay; t.bx = bx; t.by = by; t.cx = cx; t.cy = cy; t.line_x = lx;
		return t;
	endfunction

	initial begin
		localparam int ONE = 65536;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: left, right, at middle vertex, outside, degenerate, extremes
		send_triangle(tri_of(0, 0, 4*ONE, 0, 2*ONE, 2*ONE, ONE));
		send_triangle(tri_of(0, 0, 4*ONE, 0, 2*ONE, 2*ONE, 3*ONE));
		send_triangle(tri_of(0, 0, 4*ONE, 0, 2*ONE, 2*ONE, 2*ONE));
		send_triangle(tri_of(0, 0, 4*ONE, 0, 2*ONE, 2*ONE, -ONE));
		send_triangle(tri_of(0, 0, 4*ONE, 0, 2*ONE, 2*ONE, 5*ONE));
		send_triangle(tri_of(0, 0, ONE, ONE, 2*ONE, 2*ONE, ONE));
		send_triangle(tri_of(ONE, ONE, ONE, ONE, ONE, ONE, ONE));
		send_triangle(tri_of(0, 0, 0, ONE, ONE, 0, 0));
		send_triangle(tri_of(0, 0, 0, ONE, ONE, 0, ONE));
		send_triangle(tri_of(2*ONE, 0, ONE, ONE, 0, 0, ONE / 3));
		send_triangle(tri_of(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			0, 32'h7FFF_FFFF, 0));
		send_triangle(tri_of(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_triangle(tri_of(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		send_triangle(tri_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF,
			32'h8000_0000, 0, 32'hFFFF_FFFF));
		send_triangle(tri_of(0, 0, 3, 5, 7, 1, 6));

		// long receiver stall while items keep coming, so the pipe backs up
		hold_off <= 200;
		for (int i = 0; i < 60; i++) begin
			send_triangle(random_triangle());
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				send_idle = 81;
				recv_idle = 25;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			send_triangle(random_triangle());
		end
		item_valid <= 1'b0;

		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: triangle_vertical_split_ratio_core.f
+incdir+rtl
rtl/tvsr_pkg.sv
rtl/tvsr_front.sv
rtl/tvsr_div_stage.sv
rtl/triangle_vertical_split_ratio_core.sv
verif/triangle_vertical_split_ratio_checker.sv
verif/triangle_vertical_split_ratio_core_test.sv
